>>> hw/rtl/hex_delay_line_position_assert.svh
// assertion helpers for the hex delay line position block
`ifndef HEX_DELAY_LINE_POSITION_ASSERT_SVH
`define HEX_DELAY_LINE_POSITION_ASSERT_SVH

`ifndef SYNTHESIS

// same-cycle implication, checked out of reset only
`define HDLP_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("hex_delay_line_position: check failed");

// next-cycle implication, checked out of reset only
`define HDLP_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("hex_delay_line_position: check failed");

`else

`define HDLP_ASSERT_IMP(label, clk, rstn, ante, cons)
`define HDLP_ASSERT_NEXT(label, clk, rstn, ante, cons)

`endif

`endif

>>> hw/rtl/hdlp_pkg.sv
package hdlp_pkg;

    // detector side codes
    localparam logic SIDE_POS = 1'b0;
    localparam logic SIDE_NEG = 1'b1;

    // particle kind codes
    localparam logic [1:0] KIND_POSITRON = 2'd0;
    localparam logic [1:0] KIND_ION      = 2'd1;

    // destination slot codes
    typedef enum logic [1:0] {
        DEST_POSITRON = 2'd0,
        DEST_ION      = 2'd1,
        DEST_ELECTRON = 2'd2,
        DEST_DISCARD  = 2'd3
    } dest_t;

    localparam int TIME_WIDTH = 32;

    // 1/sqrt(3) in unsigned Q0.16
    localparam int           SCALE_BITS    = 16;
    localparam logic [15:0]  INV_SQRT3_Q16 = 16'd37837;

    localparam int IN_USER_WIDTH  = 6;
    localparam int OUT_USER_WIDTH = 6;

    // per-item side data that rides along the pipeline
    typedef struct packed {
        logic                   used_uv;
        logic                   used_uw;
        logic                   used_vw;
        logic                   valid_res;
        dest_t                  destination;
        logic [TIME_WIDTH-1:0]  time_out;
    } tail_t;

endpackage

>>> hw/rtl/hdlp_pair.sv
module hdlp_pair #(
    parameter int CW = 16,
    localparam int XW = CW + 3
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   en,
    input  logic                   in_valid,
    input  logic                   side,
    input  logic signed [CW-1:0]   u,
    input  logic signed [CW-1:0]   v,
    input  logic signed [CW-1:0]   w,
    input  logic                   u_single,
    input  logic                   v_single,
    input  logic                   w_single,
    input  logic [1:0]             kind,
    input  logic [hdlp_pkg::TIME_WIDTH-1:0] time_diff,
    output logic                   out_valid,
    output logic signed [XW-1:0]   xs,
    output logic signed [XW-1:0]   ys,
    output logic [1:0]             cnt,
    output hdlp_pkg::tail_t        tail
);

    logic                  valid_reg;
    logic signed [XW-1:0]  xs_reg, xs_next;
    logic signed [XW-1:0]  ys_reg, ys_next;
    logic [1:0]            cnt_reg, cnt_next;
    hdlp_pkg::tail_t       tail_reg, tail_next;

    // pair selection and numerator sums
    always_comb begin
        logic signed [XW-1:0] ue, ve, we;
        logic uv, uw, vw;
        logic fuv, fuw, fvw;
        ue = $signed({{(XW-CW){u[CW-1]}}, u});
        ve = $signed({{(XW-CW){v[CW-1]}}, v});
        we = $signed({{(XW-CW){w[CW-1]}}, w});
        uv = u_single & v_single;
        uw = u_single & w_single;
        vw = v_single & w_single;
        xs_next  = '0;
        ys_next  = '0;
        cnt_next = 2'd0;
        fuv = 1'b0;
        fuw = 1'b0;
        fvw = 1'b0;
        if (side == hdlp_pkg::SIDE_POS) begin
            // first usable pair only
            if (uv) begin
                xs_next = -ue;
                ys_next = ue - (ve <<< 1);
                fuv = 1'b1;
            end else if (uw) begin
                xs_next = -ue;
                ys_next = (we <<< 1) - ue;
                fuw = 1'b1;
            end else if (vw) begin
                xs_next = -ve - we;
                ys_next = we - ve;
                fvw = 1'b1;
            end
            cnt_next = (uv | uw | vw) ? 2'd1 : 2'd0;
        end else begin
            // mirrored formulas, every usable pair
            fuv = uv;
            fuw = uw;
            fvw = vw;
            if (uv) begin
                xs_next  = xs_next + ue;
                ys_next  = ys_next + (ve <<< 1) - ue;
                cnt_next = cnt_next + 2'd1;
            end
            if (uw) begin
                xs_next  = xs_next + ue;
                ys_next  = ys_next + (we <<< 1) + ue;
                cnt_next = cnt_next + 2'd1;
            end
            if (vw) begin
                xs_next  = xs_next + ve - we;
                ys_next  = ys_next + we + ve;
                cnt_next = cnt_next + 2'd1;
            end
        end
        tail_next.used_uv   = fuv;
        tail_next.used_uw   = fuw;
        tail_next.used_vw   = fvw;
        tail_next.valid_res = (cnt_next != 2'd0);
        tail_next.time_out  = time_diff;
        // destination decode
        if (side == hdlp_pkg::SIDE_NEG) begin
            tail_next.destination = hdlp_pkg::DEST_ELECTRON;
        end else begin
            unique case (kind)
                hdlp_pkg::KIND_POSITRON: tail_next.destination = hdlp_pkg::DEST_POSITRON;
                hdlp_pkg::KIND_ION:      tail_next.destination = hdlp_pkg::DEST_ION;
                default:                 tail_next.destination = hdlp_pkg::DEST_DISCARD;
            endcase
        end
    end

    // stage valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    // stage payload
    always_ff @(posedge aclk) begin
        if (en) begin
            xs_reg   <= xs_next;
            ys_reg   <= ys_next;
            cnt_reg  <= cnt_next;
            tail_reg <= tail_next;
        end
    end

    assign out_valid = valid_reg;
    assign xs        = xs_reg;
    assign ys        = ys_reg;
    assign cnt       = cnt_reg;
    assign tail      = tail_reg;

endmodule

>>> hw/rtl/hdlp_div.sv
module hdlp_div #(
    parameter int CW = 16,
    localparam int XW = CW + 3,
    localparam int PW = CW + 1
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   en,
    input  logic                   in_valid,
    input  logic signed [XW-1:0]   xs,
    input  logic signed [XW-1:0]   ys,
    input  logic [1:0]             cnt,
    input  hdlp_pkg::tail_t        tail_in,
    output logic                   out_valid,
    output logic signed [PW-1:0]   px,
    output logic signed [PW-1:0]   py,
    output hdlp_pkg::tail_t        tail_out
);

    // dividend width after rounding offset, product width of the y scaling
    localparam int YW = XW + hdlp_pkg::SCALE_BITS + 1;
    localparam int DW = CW + 2;
    localparam logic [DW-1:0] RECIP3 = DW'((64'd1 << DW) / 64'd3);

    // round to nearest, apply sign, saturate to the position range
    function automatic logic [PW-1:0] finish(input logic [DW-1:0] a,
                                             input logic [DW-1:0] q,
                                             input logic          neg,
                                             input logic [1:0]    c);
        logic [DW-1:0] r;
        logic [DW-1:0] q3;
        logic [DW-1:0] mag;
        logic [DW-1:0] lim;
        logic [DW-1:0] neg_mag;
        r  = a - ((q << 1) + q);
        q3 = (r >= DW'(3)) ? q + DW'(1) : q;
        case (c)
            2'd1:    mag = a;
            2'd2:    mag = a >> 1;
            2'd3:    mag = q3;
            default: mag = '0;
        endcase
        lim = neg ? (DW'(1) << (PW - 1)) : ((DW'(1) << (PW - 1)) - DW'(1));
        if (mag > lim) begin
            mag = lim;
        end
        neg_mag = ~mag + DW'(1);
        return neg ? neg_mag[PW-1:0] : mag[PW-1:0];
    endfunction

    // stage 2: y scaling product, x magnitude with rounding offset
    logic                  v2_reg;
    logic [DW-1:0]         ax2_reg, ax2_next;
    logic                  xneg2_reg;
    logic signed [YW-1:0]  yp2_reg, yp2_next;
    logic [1:0]            cnt2_reg;
    hdlp_pkg::tail_t       tail2_reg;

    // stage 3: y magnitude rounded back to the position scale
    logic                  v3_reg;
    logic [DW-1:0]         ax3_reg;
    logic [DW-1:0]         ay3_reg, ay3_next;
    logic                  xneg3_reg, yneg3_reg;
    logic [1:0]            cnt3_reg;
    hdlp_pkg::tail_t       tail3_reg;

    // stage 4: reciprocal multiply for a count of three
    logic                  v4_reg;
    logic [DW-1:0]         ax4_reg, ay4_reg;
    logic [DW-1:0]         qx4_reg, qy4_reg;
    logic [2*DW-1:0]       mx4_next, my4_next;
    logic                  xneg4_reg, yneg4_reg;
    logic [1:0]            cnt4_reg;
    hdlp_pkg::tail_t       tail4_reg;

    // stage 5: final quotient and saturation
    logic                  v5_reg;
    logic [PW-1:0]         px5_reg, py5_reg;
    hdlp_pkg::tail_t       tail5_reg;

    // x magnitude and y product
    always_comb begin
        logic [XW-1:0] xs_u;
        logic [XW-1:0] x_abs;
        xs_u     = xs;
        x_abs    = xs_u[XW-1] ? (~xs_u + XW'(1)) : xs_u;
        ax2_next = DW'(x_abs) + DW'(cnt[1]);
        yp2_next = ys * $signed({1'b0, hdlp_pkg::INV_SQRT3_Q16});
    end

    // y magnitude plus half the divisor, dropped to position scale
    always_comb begin
        logic [YW-1:0] yp_u;
        logic [YW-1:0] y_abs;
        logic [YW:0]   y_sum;
        yp_u     = yp2_reg;
        y_abs    = yp_u[YW-1] ? (~yp_u + YW'(1)) : yp_u;
        y_sum    = {1'b0, y_abs} + (YW+1)'({cnt2_reg, {(hdlp_pkg::SCALE_BITS-1){1'b0}}});
        ay3_next = DW'(y_sum >> hdlp_pkg::SCALE_BITS);
    end

    // divide by three through the reciprocal
    always_comb begin
        mx4_next = ax3_reg * RECIP3;
        my4_next = ay3_reg * RECIP3;
    end

    // valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end else if (en) begin
            v2_reg <= in_valid;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (en) begin
            ax2_reg   <= ax2_next;
            xneg2_reg <= xs[XW-1];
            yp2_reg   <= yp2_next;
            cnt2_reg  <= cnt;
            tail2_reg <= tail_in;

            ax3_reg   <= ax2_reg;
            ay3_reg   <= ay3_next;
            xneg3_reg <= xneg2_reg;
            yneg3_reg <= yp2_reg[YW-1];
            cnt3_reg  <= cnt2_reg;
            tail3_reg <= tail2_reg;

            ax4_reg   <= ax3_reg;
            ay4_reg   <= ay3_reg;
            qx4_reg   <= mx4_next[2*DW-1:DW];
            qy4_reg   <= my4_next[2*DW-1:DW];
            xneg4_reg <= xneg3_reg;
            yneg4_reg <= yneg3_reg;
            cnt4_reg  <= cnt3_reg;
            tail4_reg <= tail3_reg;

            px5_reg   <= finish(ax4_reg, qx4_reg, xneg4_reg, cnt4_reg);
            py5_reg   <= finish(ay4_reg, qy4_reg, yneg4_reg, cnt4_reg);
            tail5_reg <= tail4_reg;
        end
    end

    assign out_valid = v5_reg;
    assign px        = $signed(px5_reg);
    assign py        = $signed(py5_reg);
    assign tail_out  = tail5_reg;

endmodule

>>> hw/rtl/hdlp_root.sv
module hdlp_root #(
    parameter int CW = 16,
    localparam int PW = CW + 1
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   en,
    input  logic                   in_valid,
    input  logic signed [PW-1:0]   px_in,
    input  logic signed [PW-1:0]   py_in,
    input  hdlp_pkg::tail_t        tail_in,
    output logic                   out_valid,
    output logic [PW-1:0]          px_out,
    output logic [PW-1:0]          py_out,
    output logic [PW-1:0]          radius,
    output hdlp_pkg::tail_t        tail_out
);

    localparam int SW = 2 * PW;
    localparam int RB = PW;
    localparam int RW = RB + 3;

    // squares
    logic                  v6_reg;
    logic signed [SW-1:0]  sqx6_next, sqy6_next;
    logic [SW-1:0]         sqx6_reg, sqy6_reg;
    logic [PW-1:0]         px6_reg, py6_reg;
    hdlp_pkg::tail_t       tail6_reg;

    // sum of squares
    logic                  v7_reg;
    logic [SW-1:0]         s7_reg;
    logic [PW-1:0]         px7_reg, py7_reg;
    hdlp_pkg::tail_t       tail7_reg;

    // root digit stages, index 0 is the sum stage
    logic                  v_w    [RB+1];
    logic [SW-1:0]         s_w    [RB+1];
    logic [RW-1:0]         rem_w  [RB+1];
    logic [RB-1:0]         root_w [RB+1];
    logic [PW-1:0]         px_w   [RB+1];
    logic [PW-1:0]         py_w   [RB+1];
    hdlp_pkg::tail_t       tail_w [RB+1];

    logic                  v_stage_reg    [RB];
    logic [SW-1:0]         s_stage_reg    [RB];
    logic [RW-1:0]         rem_stage_reg  [RB];
    logic [RB-1:0]         root_stage_reg [RB];
    logic [PW-1:0]         px_stage_reg   [RB];
    logic [PW-1:0]         py_stage_reg   [RB];
    hdlp_pkg::tail_t       tail_stage_reg [RB];

    // rounding stage
    logic                  vo_reg;
    logic [PW-1:0]         rad_reg, rad_next;
    logic [PW-1:0]         pxo_reg, pyo_reg;
    hdlp_pkg::tail_t       tailo_reg;

    assign sqx6_next = px_in * px_in;
    assign sqy6_next = py_in * py_in;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v6_reg <= 1'b0;
            v7_reg <= 1'b0;
            vo_reg <= 1'b0;
        end else if (en) begin
            v6_reg <= in_valid;
            v7_reg <= v6_reg;
            vo_reg <= v_w[RB];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sqx6_reg  <= sqx6_next;
            sqy6_reg  <= sqy6_next;
            px6_reg   <= px_in;
            py6_reg   <= py_in;
            tail6_reg <= tail_in;

            s7_reg    <= sqx6_reg + sqy6_reg;
            px7_reg   <= px6_reg;
            py7_reg   <= py6_reg;
            tail7_reg <= tail6_reg;
        end
    end

    assign v_w[0]    = v7_reg;
    assign s_w[0]    = s7_reg;
    assign rem_w[0]  = '0;
    assign root_w[0] = '0;
    assign px_w[0]   = px7_reg;
    assign py_w[0]   = py7_reg;
    assign tail_w[0] = tail7_reg;

    // one result bit per stage, restoring square root
    for (genvar k = 0; k < RB; k++) begin : g_digit
        logic [RW-1:0] cur;
        logic [RW-1:0] trial;
        logic [RW-1:0] rem_next;
        logic [RB-1:0] root_next;

        always_comb begin
            cur   = {rem_w[k][RW-3:0], s_w[k][SW-1-2*k -: 2]};
            trial = RW'({root_w[k], 2'b01});
            if (cur >= trial) begin
                rem_next  = cur - trial;
                root_next = {root_w[k][RB-2:0], 1'b1};
            end else begin
                rem_next  = cur;
                root_next = {root_w[k][RB-2:0], 1'b0};
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_stage_reg[k] <= 1'b0;
            end else if (en) begin
                v_stage_reg[k] <= v_w[k];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                s_stage_reg[k]    <= s_w[k];
                rem_stage_reg[k]  <= rem_next;
                root_stage_reg[k] <= root_next;
                px_stage_reg[k]   <= px_w[k];
                py_stage_reg[k]   <= py_w[k];
                tail_stage_reg[k] <= tail_w[k];
            end
        end

        assign v_w[k+1]    = v_stage_reg[k];
        assign s_w[k+1]    = s_stage_reg[k];
        assign rem_w[k+1]  = rem_stage_reg[k];
        assign root_w[k+1] = root_stage_reg[k];
        assign px_w[k+1]   = px_stage_reg[k];
        assign py_w[k+1]   = py_stage_reg[k];
        assign tail_w[k+1] = tail_stage_reg[k];
    end

    // round to nearest and saturate
    always_comb begin
        logic [RB:0] up;
        up = {1'b0, root_w[RB]} + (RB+1)'(rem_w[RB] > RW'(root_w[RB]));
        rad_next = up[RB] ? {PW{1'b1}} : up[RB-1:0];
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rad_reg   <= rad_next;
            pxo_reg   <= px_w[RB];
            pyo_reg   <= py_w[RB];
            tailo_reg <= tail_w[RB];
        end
    end

    assign out_valid = vo_reg;
    assign px_out    = pxo_reg;
    assign py_out    = pyo_reg;
    assign radius    = rad_reg;
    assign tail_out  = tailo_reg;

endmodule

>>> hw/rtl/hex_delay_line_position.sv
// Hexagonal delay-line anode position: one detector hit in, one result out.
// A hit carries U, V, W layer positions, per-layer single-pair flags, the
// detector side and the particle kind; the result is the x/y position
// (1/sqrt(3) scaled on y, averaged over pairs on the negative side), the
// rounded radius, which pairs were used, a valid flag, the destination slot
// and the time difference passed through. A hit can be taken every clock
// cycle while the skid slot is free. Results pass the pair, divide and
// square stages and then the one-bit-per-stage square root. A two-deep output
// register keeps s_tready independent of m_tready: the input keeps flowing
// until a second finished result is held back.
`include "hex_delay_line_position_assert.svh"

module hex_delay_line_position #(
    parameter int COORD_WIDTH = 16,
    localparam int PW      = COORD_WIDTH + 1,
    localparam int IN_DW   = ((3 * COORD_WIDTH + hdlp_pkg::TIME_WIDTH + 7) / 8) * 8,
    localparam int OUT_DW  = ((3 * PW + hdlp_pkg::TIME_WIDTH + 7) / 8) * 8
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // u, v, w, time_diff
    input  logic [IN_DW-1:0]                    s_tdata,
    // side, u_single, v_single, w_single, kind
    input  logic [hdlp_pkg::IN_USER_WIDTH-1:0]  s_tuser,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // pos_x, pos_y, radius, time_out
    output logic [OUT_DW-1:0]                   m_tdata,
    // used_uv, used_uw, used_vw, valid_res, destination
    output logic [hdlp_pkg::OUT_USER_WIDTH-1:0] m_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready
);

    localparam int CW = COORD_WIDTH;
    localparam int XW = CW + 3;

    logic                  en;
    logic                  s_req;

    logic                  p1_valid;
    logic signed [XW-1:0]  p1_xs, p1_ys;
    logic [1:0]            p1_cnt;
    hdlp_pkg::tail_t       p1_tail;

    logic                  d_valid;
    logic signed [PW-1:0]  d_px, d_py;
    hdlp_pkg::tail_t       d_tail;

    logic                  r_valid;
    logic [PW-1:0]         r_px, r_py, r_rad;
    hdlp_pkg::tail_t       r_tail;

    logic [OUT_DW-1:0]                   pipe_data;
    logic [hdlp_pkg::OUT_USER_WIDTH-1:0] pipe_user;

    logic                                m_valid_reg, m_valid_next;
    logic [OUT_DW-1:0]                   m_data_reg;
    logic [hdlp_pkg::OUT_USER_WIDTH-1:0] m_user_reg;
    logic                                skid_valid_reg, skid_valid_next;
    logic [OUT_DW-1:0]                   skid_data_reg;
    logic [hdlp_pkg::OUT_USER_WIDTH-1:0] skid_user_reg;
    logic                                load_from_skid, load_from_pipe, load_skid;

    // pipeline moves whenever the skid slot is free
    assign en       = !skid_valid_reg;
    assign s_tready = en;
    assign s_req    = s_tvalid & en;

    hdlp_pair #(.CW(CW)) u_pair (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (s_req),
        .side      (s_tuser[0]),
        .u         ($signed(s_tdata[CW-1:0])),
        .v         ($signed(s_tdata[2*CW-1:CW])),
        .w         ($signed(s_tdata[3*CW-1:2*CW])),
        .u_single  (s_tuser[1]),
        .v_single  (s_tuser[2]),
        .w_single  (s_tuser[3]),
        .kind      (s_tuser[5:4]),
        .time_diff (s_tdata[3*CW+hdlp_pkg::TIME_WIDTH-1:3*CW]),
        .out_valid (p1_valid),
        .xs        (p1_xs),
        .ys        (p1_ys),
        .cnt       (p1_cnt),
        .tail      (p1_tail)
    );

    hdlp_div #(.CW(CW)) u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (p1_valid),
        .xs        (p1_xs),
        .ys        (p1_ys),
        .cnt       (p1_cnt),
        .tail_in   (p1_tail),
        .out_valid (d_valid),
        .px        (d_px),
        .py        (d_py),
        .tail_out  (d_tail)
    );

    hdlp_root #(.CW(CW)) u_root (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (d_valid),
        .px_in     (d_px),
        .py_in     (d_py),
        .tail_in   (d_tail),
        .out_valid (r_valid),
        .px_out    (r_px),
        .py_out    (r_py),
        .radius    (r_rad),
        .tail_out  (r_tail)
    );

    // pack the result
    assign pipe_data = OUT_DW'({r_tail.time_out, r_rad, r_py, r_px});
    assign pipe_user = {r_tail.destination, r_tail.valid_res,
                        r_tail.used_vw, r_tail.used_uw, r_tail.used_uv};

    // output register and skid slot control
    always_comb begin
        load_from_skid  = 1'b0;
        load_from_pipe  = 1'b0;
        load_skid       = 1'b0;
        m_valid_next    = m_valid_reg;
        skid_valid_next = skid_valid_reg;
        if (!m_valid_reg || m_tready) begin
            if (skid_valid_reg) begin
                load_from_skid  = 1'b1;
                m_valid_next    = 1'b1;
                skid_valid_next = 1'b0;
            end else if (r_valid) begin
                load_from_pipe = 1'b1;
                m_valid_next   = 1'b1;
            end else begin
                m_valid_next = 1'b0;
            end
        end else if (en && r_valid) begin
            load_skid       = 1'b1;
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg    <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            m_valid_reg    <= m_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_from_skid) begin
            m_data_reg <= skid_data_reg;
            m_user_reg <= skid_user_reg;
        end else if (load_from_pipe) begin
            m_data_reg <= pipe_data;
            m_user_reg <= pipe_user;
        end
        if (load_skid) begin
            skid_data_reg <= pipe_data;
            skid_user_reg <= pipe_user;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

    // checks
    `HDLP_ASSERT_IMP(a_skid_behind_out, aclk, aresetn, skid_valid_reg, m_valid_reg)
    `HDLP_ASSERT_NEXT(a_skid_holds, aclk, aresetn, skid_valid_reg && !m_tready, skid_valid_reg)
    `HDLP_ASSERT_IMP(a_valid_matches_used, aclk, aresetn, m_tvalid, m_tuser[3] == (m_tuser[0] || m_tuser[1] || m_tuser[2]))
    `HDLP_ASSERT_IMP(a_pos_side_one_pair, aclk, aresetn, m_tvalid && (m_tuser[5:4] != hdlp_pkg::DEST_ELECTRON), $countones(m_tuser[2:0]) <= 1)
    `HDLP_ASSERT_IMP(a_invalid_is_zero, aclk, aresetn, m_tvalid && !m_tuser[3], m_tdata[3*PW-1:0] == '0)

endmodule

>>> tb/sv/tb_hex_delay_line_position.sv
module tb_hex_delay_line_position;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int COORD_W     = 16;
    localparam int POS_W       = COORD_W + 1;
    localparam int TIME_W      = hdlp_pkg::TIME_WIDTH;
    localparam int IN_UW       = hdlp_pkg::IN_USER_WIDTH;
    localparam int OUT_UW      = hdlp_pkg::OUT_USER_WIDTH;
    localparam int IN_DW       = ((3 * COORD_W + TIME_W + 7) / 8) * 8;
    localparam int OUT_DW      = ((3 * POS_W + TIME_W + 7) / 8) * 8;
    localparam int RANDOM_HITS = 1450;
    localparam int BLOCK_HITS  = 50;
    localparam int DRAIN_WAIT  = 40;
    localparam int CYCLE_LIMIT = 400000;

    // kinds with no package code
    localparam logic [1:0] KIND_OTHER = 2'd2;
    localparam logic [1:0] KIND_SPARE = 2'd3;

    localparam longint POS_MAX = (longint'(1) << (POS_W - 1)) - 1;
    localparam longint POS_MIN = -POS_MAX - 1;
    localparam longint RAD_MAX = (longint'(1) << POS_W) - 1;

    typedef struct packed {
        logic                   side;
        logic [COORD_W-1:0]     u;
        logic [COORD_W-1:0]     v;
        logic [COORD_W-1:0]     w;
        logic                   u_single;
        logic                   v_single;
        logic                   w_single;
        logic [1:0]             kind;
        logic [TIME_W-1:0]      time_diff;
    } hit_t;

    typedef struct packed {
        logic [POS_W-1:0]       pos_x;
        logic [POS_W-1:0]       pos_y;
        logic [POS_W-1:0]       radius;
        logic                   used_uv;
        logic                   used_uw;
        logic                   used_vw;
        logic                   valid_res;
        hdlp_pkg::dest_t        destination;
        logic [TIME_W-1:0]      time_out;
    } fix_t;

    // keeps the positions still owed by the block, in request order
    class position_checker;
        fix_t pending_fixes[$];
        int   errors;
        int   results_seen;

        function new();
            errors       = 0;
            results_seen = 0;
        endfunction

        // nearest, ties away from zero; d > 0
        function longint round_div(longint n, longint d);
            longint mag;
            longint q;
            mag = (n < 0) ? -n : n;
            q   = (mag + d / 2) / d;
            return (n < 0) ? -q : q;
        endfunction

        function longint clamp_pos(longint x);
            if (x > POS_MAX) return POS_MAX;
            if (x < POS_MIN) return POS_MIN;
            return x;
        endfunction

        function fix_t predict_position(hit_t h);
            longint lu, lv, lw, xs, ys, cnt, px, py, sq, r, t;
            bit     uv, uw, vw;
            fix_t   f;
            lu  = $signed(h.u);
            lv  = $signed(h.v);
            lw  = $signed(h.w);
            uv  = h.u_single && h.v_single;
            uw  = h.u_single && h.w_single;
            vw  = h.v_single && h.w_single;
            xs  = 0;
            ys  = 0;
            cnt = 0;
            px  = 0;
            py  = 0;
            r   = 0;
            f   = '0;

            if (h.side == hdlp_pkg::SIDE_POS) begin
                // first usable pair wins: uv, then uw, then vw
                if (uv) begin
                    uw = 0;
                    vw = 0;
                    xs = -lu;
                    ys = lu - 2 * lv;
                end else if (uw) begin
                    vw = 0;
                    xs = -lu;
                    ys = 2 * lw - lu;
                end else if (vw) begin
                    xs = -lv - lw;
                    ys = lw - lv;
                end
                cnt = (uv || uw || vw) ? 1 : 0;
                if (h.kind == hdlp_pkg::KIND_POSITRON)
                    f.destination = hdlp_pkg::DEST_POSITRON;
                else if (h.kind == hdlp_pkg::KIND_ION)
                    f.destination = hdlp_pkg::DEST_ION;
                else
                    f.destination = hdlp_pkg::DEST_DISCARD;
            end else begin
                // mirrored formulas, every usable pair summed
                if (uv) begin
                    xs += lu;
                    ys += 2 * lv - lu;
                    cnt++;
                end
                if (uw) begin
                    xs += lu;
                    ys += 2 * lw + lu;
                    cnt++;
                end
                if (vw) begin
                    xs += lv - lw;
                    ys += lw + lv;
                    cnt++;
                end
                f.destination = hdlp_pkg::DEST_ELECTRON;
            end

            if (cnt > 0) begin
                px = clamp_pos(round_div(xs, cnt));
                py = clamp_pos(round_div(ys * longint'(hdlp_pkg::INV_SQRT3_Q16),
                                         cnt * (longint'(1) << hdlp_pkg::SCALE_BITS)));
                sq = px * px + py * py;
                // floor root bit by bit, then round to nearest
                for (int b = POS_W; b >= 0; b--) begin
                    t = r | (longint'(1) << b);
                    if (t * t <= sq) r = t;
                end
                if (sq - r * r > r) r++;
                if (r > RAD_MAX) r = RAD_MAX;
            end

            f.pos_x     = px[POS_W-1:0];
            f.pos_y     = py[POS_W-1:0];
            f.radius    = r[POS_W-1:0];
            f.used_uv   = uv;
            f.used_uw   = uw;
            f.used_vw   = vw;
            f.valid_res = (cnt > 0);
            f.time_out  = h.time_diff;
            return f;
        endfunction

        function void note_hit(hit_t h);
            pending_fixes.push_back(predict_position(h));
        endfunction

        function int pending_count();
            return pending_fixes.size();
        endfunction

        task report_mismatch(string msg);
            $display("result %0d: %s", results_seen, msg);
            errors++;
        endtask

        task compare_field(string name, longint got, longint want);
            if (got != want)
                report_mismatch($sformatf("%s got %0h, expected %0h", name, got, want));
        endtask

        task check_fix(logic [OUT_DW-1:0] data, logic [OUT_UW-1:0] user);
            fix_t want;
            if (pending_fixes.size() == 0) begin
                report_mismatch("result with no request pending");
                results_seen++;
                return;
            end
            want = pending_fixes.pop_front();
            compare_field("pos_x", data[POS_W-1:0], want.pos_x);
            compare_field("pos_y", data[2*POS_W-1:POS_W], want.pos_y);
            compare_field("radius", data[3*POS_W-1:2*POS_W], want.radius);
            compare_field("time_out", data[3*POS_W+TIME_W-1:3*POS_W], want.time_out);
            compare_field("used_uv", user[0], want.used_uv);
            compare_field("used_uw", user[1], want.used_uw);
            compare_field("used_vw", user[2], want.used_vw);
            compare_field("valid_res", user[3], want.valid_res);
            compare_field("destination", user[5:4], want.destination);
            results_seen++;
        endtask
    endclass

    logic                       aclk     = 1'b0;
    logic                       aresetn  = 1'b0;
    logic [IN_DW-1:0]           s_tdata  = '0;
    logic [IN_UW-1:0]           s_tuser  = '0;
    logic                       s_tvalid = 1'b0;
    logic                       s_tready;
    logic [OUT_DW-1:0]          m_tdata;
    logic [OUT_UW-1:0]          m_tuser;
    logic                       m_tvalid;
    logic                       m_tready = 1'b0;

    // when set, that side runs without gaps
    bit src_calm = 1'b1;
    bit snk_calm = 1'b1;
    int cycle_count = 0;

    position_checker pos_checker = new();

    hex_delay_line_position #(
        .COORD_WIDTH(COORD_W)
    ) u_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready)
    );

    // 100 MHz clock
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // run limit
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", CYCLE_LIMIT);
            $display("CHECK FAILED");
            $finish;
        end
    end

    function hit_t make_hit(logic sd, int u, int v, int w, logic su, logic sv, logic sw,
                            logic [1:0] k, logic [TIME_W-1:0] td);
        hit_t h;
        h.side      = sd;
        h.u         = u[COORD_W-1:0];
        h.v         = v[COORD_W-1:0];
        h.w         = w[COORD_W-1:0];
        h.u_single  = su;
        h.v_single  = sv;
        h.w_single  = sw;
        h.kind      = k;
        h.time_diff = td;
        return h;
    endfunction

    // mostly full range, with extremes and values near zero mixed in
    function int random_coord();
        case ($urandom_range(0, 7))
            0:       return -32768;
            1:       return 32767;
            2:       return $urandom_range(0, 64) - 32;
            default: return int'($urandom);
        endcase
    endfunction

    function hit_t random_hit();
        logic [1:0] k;
        k = ($urandom_range(0, 15) == 0) ? KIND_SPARE : 2'($urandom_range(0, 2));
        return make_hit(1'($urandom_range(0, 1)), random_coord(), random_coord(),
                        random_coord(),
                        ($urandom_range(0, 3) != 0), ($urandom_range(0, 3) != 0),
                        ($urandom_range(0, 3) != 0), k, $urandom);
    endfunction

    // one request on the input side, with a random gap first
    task send_hit(hit_t h);
        int gap;
        logic [IN_DW-1:0] data;
        gap = src_calm ? 0 : $urandom_range(0, 13);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        data = '0;
        data[COORD_W-1:0]           = h.u;
        data[2*COORD_W-1:COORD_W]   = h.v;
        data[3*COORD_W-1:2*COORD_W] = h.w;
        data[3*COORD_W+TIME_W-1:3*COORD_W] = h.time_diff;
        s_tdata  <= data;
        s_tuser  <= {h.kind, h.w_single, h.v_single, h.u_single, h.side};
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        pos_checker.note_hit(h);
    endtask

    // result side: random stalls, check each accepted result
    initial begin
        int gap;
        wait (aresetn === 1'b1);
        forever begin
            gap = snk_calm ? 0 : $urandom_range(0, 13);
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            pos_checker.check_fix(m_tdata, m_tuser);
        end
    end

    // stimulus and end of run
    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: each pair alone, all pairs, no pair, extremes, every kind
        send_hit(make_hit(hdlp_pkg::SIDE_POS, 32767, -32768, 1234, 1, 1, 1,
                          hdlp_pkg::KIND_POSITRON, 32'h0));
        send_hit(make_hit(hdlp_pkg::SIDE_POS, -32768, 0, 32767, 1, 0, 1,
                          hdlp_pkg::KIND_ION, 32'h7fffffff));
        send_hit(make_hit(hdlp_pkg::SIDE_POS, 100, -32768, -32768, 0, 1, 1,
                          KIND_OTHER, 32'h80000000));
        send_hit(make_hit(hdlp_pkg::SIDE_POS, 32767, 32767, 32767, 0, 0, 1,
                          KIND_SPARE, 32'hffffffff));
        send_hit(make_hit(hdlp_pkg::SIDE_POS, 0, 0, 0, 0, 0, 0,
                          hdlp_pkg::KIND_POSITRON, 32'h0));
        send_hit(make_hit(hdlp_pkg::SIDE_POS, -32768, -32768, -32768, 1, 1, 0,
                          hdlp_pkg::KIND_ION, 32'h1));
        send_hit(make_hit(hdlp_pkg::SIDE_NEG, 32767, 32767, 32767, 1, 1, 1,
                          hdlp_pkg::KIND_POSITRON, 32'd12345));
        send_hit(make_hit(hdlp_pkg::SIDE_NEG, -32768, -32768, -32768, 1, 1, 1,
                          hdlp_pkg::KIND_ION, 32'hdeadbeef));
        send_hit(make_hit(hdlp_pkg::SIDE_NEG, -32768, 32767, -32768, 1, 1, 0,
                          KIND_OTHER, 32'h5555aaaa));
        send_hit(make_hit(hdlp_pkg::SIDE_NEG, -32768, 0, -32768, 1, 0, 1,
                          KIND_SPARE, 32'haaaa5555));
        send_hit(make_hit(hdlp_pkg::SIDE_NEG, 0, 32767, -32768, 0, 1, 1,
                          hdlp_pkg::KIND_POSITRON, 32'h0));
        send_hit(make_hit(hdlp_pkg::SIDE_NEG, 5, -7, 3, 0, 0, 0,
                          hdlp_pkg::KIND_ION, 32'h7fffffff));
        send_hit(make_hit(hdlp_pkg::SIDE_NEG, 1, 0, 0, 1, 0, 0,
                          KIND_OTHER, 32'h80000000));
        send_hit(make_hit(hdlp_pkg::SIDE_POS, 16, -16, 8, 0, 1, 0,
                          KIND_OTHER, 32'hffffffff));
        send_hit(make_hit(hdlp_pkg::SIDE_POS, 1, 2, 3, 1, 1, 1,
                          hdlp_pkg::KIND_POSITRON, 32'h00ff00ff));
        send_hit(make_hit(hdlp_pkg::SIDE_NEG, 3, -5, 7, 1, 1, 1,
                          hdlp_pkg::KIND_ION, 32'hff00ff00));
        send_hit(make_hit(hdlp_pkg::SIDE_POS, -1, 1, -1, 1, 0, 1,
                          hdlp_pkg::KIND_ION, 32'h12345678));

        // random hits in blocks, each block with its own idling mix
        for (int i = 0; i < RANDOM_HITS; i++) begin
            if (i % BLOCK_HITS == 0) begin
                src_calm = ($urandom_range(0, 3) == 0);
                snk_calm = ($urandom_range(0, 3) == 0);
            end
            send_hit(random_hit());
        end
        s_tvalid <= 1'b0;

        // drain, then give a stray result time to show up
        while (pos_checker.pending_count() != 0) @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);
        if (pos_checker.errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
